[hdl/ccs_pkg.sv]
package ccs_pkg;

    // Scan modes
    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_FG0  = 3'd1;
    localparam logic [2:0] MODE_FG1  = 3'd2;
    localparam logic [2:0] MODE_FG2  = 3'd3;
    localparam logic [2:0] MODE_BG0  = 3'd4;
    localparam logic [2:0] MODE_BG1  = 3'd5;

    // Format codes
    localparam logic [7:0] CODE_CTCP      = 8'd1;
    localparam logic [7:0] CODE_BOLD      = 8'd2;
    localparam logic [7:0] CODE_COLOUR    = 8'd3;
    localparam logic [7:0] CODE_PLAIN     = 8'd15;
    localparam logic [7:0] CODE_REVERSE   = 8'd22;
    localparam logic [7:0] CODE_UNDERLINE = 8'd31;
    localparam logic [7:0] CODE_COMMA     = 8'h2C;
    localparam logic [7:0] CODE_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CODE_DIGIT_HI  = 8'h39;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] char_out;
        logic       keep;
        logic       last_out;
    } t_out_beat;

endpackage

[hdl/ccs_scan.sv]
module ccs_scan
    import ccs_pkg::*;
(
    input  logic [2:0] i_mode,
    input  t_in_beat   i_beat,
    output logic [2:0] o_mode,
    output t_out_beat  o_beat
);

    logic [7:0] w_c;
    logic       w_digit;
    logic       w_comma;
    logic       w_plain_keep;
    logic [2:0] w_plain_mode;
    logic       w_keep;
    logic [2:0] w_mode;

    assign w_c     = i_beat.char_in;
    assign w_digit = (w_c >= CODE_DIGIT_LO) && (w_c <= CODE_DIGIT_HI);
    assign w_comma = (w_c == CODE_COMMA);

    // byte taken as ordinary text
    always_comb begin
        w_plain_keep = 1'b1;
        w_plain_mode = MODE_TEXT;
        if (w_c == CODE_COLOUR) begin
            w_plain_keep = 1'b0;
            w_plain_mode = MODE_FG0;
        end else if (w_c == CODE_CTCP || w_c == CODE_BOLD || w_c == CODE_PLAIN ||
                     w_c == CODE_REVERSE || w_c == CODE_UNDERLINE) begin
            w_plain_keep = 1'b0;
        end
    end

    always_comb begin
        w_keep = w_plain_keep;
        w_mode = w_plain_mode;
        unique case (i_mode)
            MODE_FG0: begin
                if (w_digit) begin
                    w_keep = 1'b0;
                    w_mode = MODE_FG1;
                end
            end
            MODE_FG1: begin
                if (w_digit) begin
                    w_keep = 1'b0;
                    w_mode = MODE_FG2;
                end else if (w_comma) begin
                    w_keep = 1'b0;
                    w_mode = MODE_BG0;
                end
            end
            MODE_FG2: begin
                if (w_comma) begin
                    w_keep = 1'b0;
                    w_mode = MODE_BG0;
                end
            end
            MODE_BG0: begin
                if (w_digit) begin
                    w_keep = 1'b0;
                    w_mode = MODE_BG1;
                end
            end
            MODE_BG1: begin
                if (w_digit) begin
                    w_keep = 1'b0;
                    w_mode = MODE_TEXT;
                end
            end
            default: begin
                w_keep = w_plain_keep;
                w_mode = w_plain_mode;
            end
        endcase
    end

    // message end drops any open colour code
    assign o_mode = i_beat.last_in ? MODE_TEXT : w_mode;
    // char_out, keep, last_out
    assign o_beat = {w_c, w_keep, i_beat.last_in};

endmodule

[hdl/chat_format_code_stripper.sv]
// Chat format code stripper.
// Input channel: i_in_valid / o_in_ready carry one text byte per beat
// (i_in_beat: char_in, last_in). Output channel: o_out_valid / i_out_ready
// carry one result beat per input beat (o_out_beat: char_out, keep,
// last_out); char_out is the byte unchanged, keep = 0 marks a format byte.
// Path: a beat accepted into the input register moves on into the result
// register when that is free or being emptied, and shows on the output
// from there. Throughput: one beat per cycle while i_out_ready stays high;
// the scan mode register is updated once per beat as a beat moves from
// the input to the result register.
// Stall: while the receiver holds i_out_ready low the result register
// holds; one more beat is still taken into the input register, after
// which o_in_ready drops until the result is taken.
// Reset (i_rst_n low, synchronous): both registers empty, scan mode back
// to normal text. A beat with last_in set also returns the mode to text.
module chat_format_code_stripper
    import ccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;
    logic [2:0] r_mode;

    logic       w_advance;
    logic [2:0] n_mode;
    t_out_beat  n_out;

    // input register moves on when the result register is free or emptying
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    ccs_scan u_scan (
        .i_mode (r_mode),
        .i_beat (r_in),
        .o_mode (n_mode),
        .o_beat (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_TEXT;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // last beat of a message leaves the scanner in text mode
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.last_in) |=> (r_mode == MODE_TEXT))
        else $error("scan mode not cleared after last beat");

    // back-pressure only when both stages hold a beat
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // single-byte format codes are always dropped; checked here for bold
    a_bold_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.char_out == CODE_BOLD) |-> !o_out_beat.keep)
        else $error("format code kept");

endmodule
